[hw/rtl/hpt_pkg.sv]
// Shared types and constants for the histogram peak tracker.
package hpt_pkg;

    localparam int NBINS     = 1024;
    localparam int BIN_W     = 10;
    localparam int NB_W      = 11;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int ST_W      = 2;
    localparam int LEVEL_W   = 17;
    localparam int FRAC_BITS = 16;
    localparam int K_W       = 5;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

    // classified command word handed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              outside;
        logic [DATA_W-1:0] diff;
        logic [BIN_W-1:0]  first;
        logic [BIN_W-1:0]  last;
        logic              range_bad;
    } hpt_op_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [BIN_W-1:0]   bin;
        logic [DATA_W-1:0]  peak_count;
        logic [BIN_W-1:0]   peak_bin;
        logic [LEVEL_W-1:0] level;
        logic [DATA_W-1:0]  last_index;
    } hpt_res_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } hpt_q_stat_t;

endpackage

[hw/rtl/hpt_if.sv]
// Channel interfaces: command input, result output, configuration writes.
interface hpt_in_if;
    logic                          valid;
    logic                          ready;
    logic [hpt_pkg::CMD_W-1:0]     cmd;
    logic signed [hpt_pkg::DATA_W-1:0] sample;
    logic [hpt_pkg::BIN_W-1:0]     first_bin;
    logic [hpt_pkg::BIN_W-1:0]     last_bin;
    modport source (output valid, cmd, sample, first_bin, last_bin, input ready);
    modport sink (input valid, cmd, sample, first_bin, last_bin, output ready);
endinterface

interface hpt_out_if;
    logic                          valid;
    logic                          ready;
    logic [hpt_pkg::ST_W-1:0]      status;
    logic [hpt_pkg::BIN_W-1:0]     bin;
    logic [hpt_pkg::DATA_W-1:0]    peak_count;
    logic [hpt_pkg::BIN_W-1:0]     peak_bin;
    logic [hpt_pkg::LEVEL_W-1:0]   level;
    logic [hpt_pkg::DATA_W-1:0]    last_index;
    modport source (output valid, status, bin, peak_count, peak_bin, level, last_index,
                    input ready);
    modport sink (input valid, status, bin, peak_count, peak_bin, level, last_index,
                  output ready);
endinterface

interface hpt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hpt_pkg::CFG_IDX_W-1:0]  index;
    logic [hpt_pkg::DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/hpt_front.sv]
// Front end: input handshake and command classification.
module hpt_front (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hpt_pkg::CMD_W-1:0]     cmd,
    input  logic signed [hpt_pkg::DATA_W-1:0] sample,
    input  logic [hpt_pkg::BIN_W-1:0]     first_bin,
    input  logic [hpt_pkg::BIN_W-1:0]     last_bin,
    input  logic [hpt_pkg::DATA_W-1:0]    low_edge,
    input  logic [hpt_pkg::DATA_W-1:0]    range_width,
    input  logic [hpt_pkg::NB_W-1:0]      nb,
    input  hpt_pkg::hpt_q_stat_t          q_stat,
    input  logic                          init_busy,
    output logic                          push,
    output hpt_pkg::hpt_op_t              op
);

    logic [hpt_pkg::DATA_W:0] diff;

    // 33-bit signed difference; sign bit marks below the bottom edge
    assign diff = {sample[hpt_pkg::DATA_W-1], sample}
                - {low_edge[hpt_pkg::DATA_W-1], low_edge};

    assign in_ready = !q_stat.full && !init_busy;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        op.cmd       = cmd;
        op.diff      = diff[hpt_pkg::DATA_W-1:0];
        // diff >= range_width means bin >= B; also covers range_width of zero
        op.outside   = diff[hpt_pkg::DATA_W] || (diff[hpt_pkg::DATA_W-1:0] >= range_width);
        op.first     = first_bin;
        op.last      = last_bin;
        op.range_bad = (first_bin > last_bin) || ({1'b0, last_bin} >= nb);
    end

endmodule

[hw/rtl/hpt_queue.sv]
// Short queue of classified command words between front and back.
module hpt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hpt_pkg::hpt_op_t     push_op,
    input  logic                 pop,
    output hpt_pkg::hpt_q_stat_t q_stat,
    output hpt_pkg::hpt_op_t     head_op
);

    hpt_pkg::hpt_op_t            entry_reg [hpt_pkg::QDEPTH];
    logic [hpt_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [hpt_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [hpt_pkg::QPTR_W:0]    count_reg, count_next;

    assign q_stat.full       = (count_reg == (hpt_pkg::QPTR_W+1)'(hpt_pkg::QDEPTH));
    assign q_stat.head_valid = (count_reg != '0);
    assign head_op           = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (hpt_pkg::QPTR_W+1)'(push) - (hpt_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[hw/rtl/hpt_back.sv]
// Back end: bin division, count memory update, range query and clear sweep.
module hpt_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  hpt_pkg::hpt_op_t           q_op,
    output logic                       pop,
    input  logic [hpt_pkg::NB_W-1:0]   nb,
    input  logic [hpt_pkg::DATA_W-1:0] range_width,
    output logic                       init_busy,
    output logic                       out_valid,
    input  logic                       out_ready,
    output hpt_pkg::hpt_res_t          out_res
);

    localparam int NUM_W = hpt_pkg::NB_W + hpt_pkg::DATA_W;
    localparam int SUM_W = COUNT_WIDTH + hpt_pkg::BIN_W;
    localparam int DEN_W = COUNT_WIDTH + hpt_pkg::NB_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_QSUM = 4'd6;
    localparam logic [3:0] S_QMUL = 4'd7;
    localparam logic [3:0] S_QCMP = 4'd8;
    localparam logic [3:0] S_QDIV = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [COUNT_WIDTH-1:0]     cnt_mem [hpt_pkg::NBINS];
    logic [hpt_pkg::DATA_W-1:0] last_mem [hpt_pkg::NBINS];
    logic [COUNT_WIDTH-1:0]     cnt_rd_reg;
    logic [hpt_pkg::DATA_W-1:0] last_rd_reg;

    logic [3:0]                 state_reg, state_next;
    logic                       init_reg, init_next;
    logic                       pend_reg, pend_next;
    logic                       out_valid_reg, out_valid_next;
    hpt_pkg::hpt_op_t           op_reg, op_next;
    logic [hpt_pkg::NB_W-1:0]   addr_reg, addr_next;
    logic [hpt_pkg::K_W-1:0]    k_reg, k_next;
    logic [NUM_W-1:0]           drem_reg, drem_next;
    logic [hpt_pkg::BIN_W-1:0]  bin_reg, bin_next;
    logic [hpt_pkg::DATA_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [DEN_W-1:0]           den_reg, den_next;
    logic [DEN_W-1:0]           qrem_reg, qrem_next;
    logic [hpt_pkg::FRAC_BITS-1:0] lq_reg, lq_next;
    logic [COUNT_WIDTH-1:0]     peak_reg, peak_next;
    logic [hpt_pkg::BIN_W-1:0]  peak_bin_reg, peak_bin_next;
    logic [hpt_pkg::DATA_W-1:0] snum_reg, snum_next;
    logic [hpt_pkg::ST_W-1:0]   status_reg, status_next;
    logic [hpt_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [hpt_pkg::DATA_W-1:0] lastidx_reg, lastidx_next;
    hpt_pkg::hpt_res_t          out_res_reg, out_res_next;

    logic                       cnt_we, last_we, last_re, issue;
    logic [hpt_pkg::BIN_W-1:0]  wr_addr, cnt_raddr, last_raddr;
    logic [COUNT_WIDTH-1:0]     cnt_wdata, new_cnt;
    logic [hpt_pkg::DATA_W-1:0] last_wdata;
    logic [NUM_W-1:0]           trial;
    logic [DEN_W:0]             qrem2;
    logic [hpt_pkg::NB_W-1:0]   span;

    assign init_busy = init_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign trial   = NUM_W'(range_width) << k_reg;
    assign qrem2   = {qrem_reg, 1'b0};
    assign new_cnt = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
    assign span    = {1'b0, op_reg.last} - {1'b0, op_reg.first} + 1'b1;
    assign issue   = (addr_reg <= {1'b0, op_reg.last});

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        pend_next      = pend_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        k_next         = k_reg;
        drem_next      = drem_reg;
        bin_next       = bin_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        den_next       = den_reg;
        qrem_next      = qrem_reg;
        lq_next        = lq_reg;
        peak_next      = peak_reg;
        peak_bin_next  = peak_bin_reg;
        snum_next      = snum_reg;
        status_next    = status_reg;
        level_next     = level_reg;
        lastidx_next   = lastidx_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        cnt_we         = 1'b0;
        last_we        = 1'b0;
        last_re        = 1'b0;
        wr_addr        = bin_reg;
        cnt_wdata      = '0;
        last_wdata     = '0;
        cnt_raddr      = addr_reg[hpt_pkg::BIN_W-1:0];
        last_raddr     = q_op.first;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop          = 1'b1;
                    op_next      = q_op;
                    status_next  = hpt_pkg::ST_OK;
                    bin_next     = '0;
                    level_next   = '0;
                    lastidx_next = '0;
                    unique case (q_op.cmd)
                        hpt_pkg::CMD_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = S_CLR;
                        end
                        hpt_pkg::CMD_ADD:
                        begin
                            idx_next  = snum_reg;
                            snum_next = snum_reg + 1'b1;
                            if (q_op.outside)
                            begin
                                status_next = hpt_pkg::ST_OUTSIDE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        hpt_pkg::CMD_QUERY:
                        begin
                            if (q_op.range_bad)
                            begin
                                status_next = hpt_pkg::ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                addr_next  = {1'b0, q_op.first};
                                pend_next  = 1'b0;
                                sum_next   = '0;
                                last_re    = 1'b1;
                                state_next = S_QSUM;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                cnt_we    = 1'b1;
                last_we   = 1'b1;
                wr_addr   = addr_reg[hpt_pkg::BIN_W-1:0];
                addr_next = addr_reg + 1'b1;
                if (addr_reg[hpt_pkg::BIN_W-1:0] == hpt_pkg::BIN_W'(hpt_pkg::NBINS - 1))
                begin
                    peak_next     = '0;
                    peak_bin_next = '0;
                    snum_next     = '0;
                    init_next     = 1'b0;
                    state_next    = init_reg ? S_IDLE : S_DONE;
                end
            end
            S_MUL:
            begin
                drem_next  = NUM_W'(nb) * NUM_W'(op_reg.diff);
                k_next     = hpt_pkg::K_W'(hpt_pkg::BIN_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // quotient is known to be below B, so ten bits suffice
                if (drem_reg >= trial)
                begin
                    drem_next = drem_reg - trial;
                    bin_next  = bin_reg | (hpt_pkg::BIN_W'(1) << k_reg);
                end
                if (k_reg == '0)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end
            S_RD:
            begin
                cnt_raddr  = bin_reg;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cnt_we     = 1'b1;
                cnt_wdata  = new_cnt;
                last_we    = 1'b1;
                last_wdata = idx_reg;
                if (new_cnt > peak_reg)
                begin
                    peak_next     = new_cnt;
                    peak_bin_next = bin_reg;
                end
                state_next = S_DONE;
            end
            S_QSUM:
            begin
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(cnt_rd_reg);
                end
                pend_next = issue;
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_QMUL;
                end
            end
            S_QMUL:
            begin
                lastidx_next = last_rd_reg;
                den_next     = DEN_W'(peak_reg) * DEN_W'(span);
                if (peak_reg == '0)
                begin
                    level_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_QCMP;
                end
            end
            S_QCMP:
            begin
                if (DEN_W'(sum_reg) >= den_reg)
                begin
                    level_next = hpt_pkg::LEVEL_ONE;
                    state_next = S_DONE;
                end
                else
                begin
                    qrem_next  = DEN_W'(sum_reg);
                    lq_next    = '0;
                    k_next     = hpt_pkg::K_W'(hpt_pkg::FRAC_BITS - 1);
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (qrem2 >= {1'b0, den_reg})
                begin
                    qrem_next = DEN_W'(qrem2 - {1'b0, den_reg});
                    lq_next   = {lq_reg[hpt_pkg::FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    qrem_next = qrem2[DEN_W-1:0];
                    lq_next   = {lq_reg[hpt_pkg::FRAC_BITS-2:0], 1'b0};
                end
                if (k_reg == '0)
                begin
                    level_next = {1'b0, lq_next};
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_res_next.status     = status_reg;
                    out_res_next.bin        = bin_reg;
                    out_res_next.peak_count = hpt_pkg::DATA_W'(peak_reg);
                    out_res_next.peak_bin   = peak_bin_reg;
                    out_res_next.level      = level_reg;
                    out_res_next.last_index = lastidx_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            k_reg         <= '0;
            peak_reg      <= '0;
            peak_bin_reg  <= '0;
            snum_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            addr_reg      <= addr_next;
            k_reg         <= k_next;
            peak_reg      <= peak_next;
            peak_bin_reg  <= peak_bin_next;
            snum_reg      <= snum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        drem_reg    <= drem_next;
        bin_reg     <= bin_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        den_reg     <= den_next;
        qrem_reg    <= qrem_next;
        lq_reg      <= lq_next;
        status_reg  <= status_next;
        level_reg   <= level_next;
        lastidx_reg <= lastidx_next;
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[wr_addr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (last_we)
        begin
            last_mem[wr_addr] <= last_wdata;
        end
        if (last_re)
        begin
            last_rd_reg <= last_mem[last_raddr];
        end
    end

endmodule

[hw/rtl/histogram_peak_tracker.sv]
// Top level of the histogram peak tracker: config registers, front, queue, back.
//
//  channel  dir  handshake     word
//  in_ch    in   valid/ready   cmd, sample, first_bin, last_bin
//  out_ch   out  valid/ready   status, bin, peak_count, peak_bin, level, last_index
//  cfg_ch   in   valid/ready   index, data (ready always high)
//
// Add: multiply, 10-step bin division, count read, write, result; an ignored sample
// goes straight to the result.
// Query: the count memory read port sums one bin a cycle, then, unless the peak is
// zero or the level caps at one, a 16-step divider forms the level. Clear: a sweep over all NBINS bins.
// After reset a clearing pass zeroes the memories; no word is taken then.
// A two-entry queue lets the front accept while the back works; the output register
// holds a result under stall while the back goes on with the next word.
module histogram_peak_tracker #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    hpt_in_if.sink     in_ch,
    hpt_out_if.source  out_ch,
    hpt_cfg_if.sink    cfg_ch
);

    logic [hpt_pkg::DATA_W-1:0] low_edge_reg;
    logic [hpt_pkg::DATA_W-1:0] range_width_reg;
    logic [hpt_pkg::NB_W-1:0]   bin_count_reg;
    logic [hpt_pkg::NB_W-1:0]   nb;
    logic                       push, pop, init_busy;
    hpt_pkg::hpt_op_t           push_op, head_op;
    hpt_pkg::hpt_q_stat_t       q_stat;
    hpt_pkg::hpt_res_t          res;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_edge_reg    <= '0;
            range_width_reg <= 32'd65536;
            bin_count_reg   <= 11'd1024;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                hpt_pkg::REG_LOW_EDGE:    low_edge_reg    <= cfg_ch.data;
                hpt_pkg::REG_RANGE_WIDTH: range_width_reg <= cfg_ch.data;
                hpt_pkg::REG_BIN_COUNT:   bin_count_reg   <= cfg_ch.data[hpt_pkg::NB_W-1:0];
                default:                  ;
            endcase
        end
    end

    // bins in use, clamped to 1..NBINS
    always_comb
    begin
        priority if (bin_count_reg == '0)
        begin
            nb = hpt_pkg::NB_W'(1);
        end
        else if (bin_count_reg > hpt_pkg::NB_W'(hpt_pkg::NBINS))
        begin
            nb = hpt_pkg::NB_W'(hpt_pkg::NBINS);
        end
        else
        begin
            nb = bin_count_reg;
        end
    end

    hpt_front u_front (
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .cmd         (in_ch.cmd),
        .sample      (in_ch.sample),
        .first_bin   (in_ch.first_bin),
        .last_bin    (in_ch.last_bin),
        .low_edge    (low_edge_reg),
        .range_width (range_width_reg),
        .nb          (nb),
        .q_stat      (q_stat),
        .init_busy   (init_busy),
        .push        (push),
        .op          (push_op)
    );

    hpt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .q_stat  (q_stat),
        .head_op (head_op)
    );

    hpt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_stat.head_valid),
        .q_op        (head_op),
        .pop         (pop),
        .nb          (nb),
        .range_width (range_width_reg),
        .init_busy   (init_busy),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_res     (res)
    );

    assign out_ch.status     = res.status;
    assign out_ch.bin        = res.bin;
    assign out_ch.peak_count = res.peak_count;
    assign out_ch.peak_bin   = res.peak_bin;
    assign out_ch.level      = res.level;
    assign out_ch.last_index = res.last_index;

    // the power-up clearing pass runs once only
    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(init_busy))
        else $error("clearing pass restarted");

    a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.level <= hpt_pkg::LEVEL_ONE)
        else $error("level above one");

    a_bad_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == hpt_pkg::ST_RANGE
        |-> out_ch.level == '0 && out_ch.last_index == '0 && out_ch.bin == '0)
        else $error("invalid query carries data");

    a_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == hpt_pkg::ST_OUTSIDE
        |-> out_ch.bin == '0 && out_ch.level == '0)
        else $error("ignored sample carries data");

endmodule

[dv/hpt_tb_if.sv]
// Testbench-side interface instances are the RTL interfaces; this file holds the result word type.
`timescale 1ns / 1ps
package hpt_tb_pkg;

    typedef struct {
        logic [hpt_pkg::ST_W-1:0]    status;
        logic [hpt_pkg::BIN_W-1:0]   bin;
        logic [hpt_pkg::DATA_W-1:0]  peak_count;
        logic [hpt_pkg::BIN_W-1:0]   peak_bin;
        logic [hpt_pkg::LEVEL_W-1:0] level;
        logic [hpt_pkg::DATA_W-1:0]  last_index;
    } hist_res_t;
endpackage

[dv/testbench.sv]
// Self-checking testbench for histogram_peak_tracker: predicts every result word.
`timescale 1ns / 1ps
module testbench;

    // Histogram predictor plus queue of expected result words.
    class hist_scoreboard;
        bit [31:0] counts[hpt_pkg::NBINS];
        bit [31:0] last_seen[hpt_pkg::NBINS];
        bit [31:0] peak;
        bit [9:0]  peak_at;
        bit [31:0] add_index;
        bit signed [31:0] lo_edge;
        bit [31:0] span;
        bit [10:0] nbins_reg;
        hpt_tb_pkg::hist_res_t pending[$];
        int errors;

        function void wipe();
            foreach (counts[i]) begin
                counts[i] = 0;
                last_seen[i] = 0;
            end
            peak = 0;
            peak_at = 0;
            add_index = 0;
        endfunction

        function void reset_state();
            wipe();
            lo_edge = 0;
            span = 65536;
            nbins_reg = 1024;
            errors = 0;
        endfunction

        function void write_reg(logic [hpt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                hpt_pkg::REG_LOW_EDGE:    lo_edge = d;
                hpt_pkg::REG_RANGE_WIDTH: span = d;
                hpt_pkg::REG_BIN_COUNT:   nbins_reg = d[10:0];
                default: ;
            endcase
        endfunction

        // level = floor(sum*65536 / (n*peak)), capped at one
        function bit [16:0] range_level(int first, int last);
            bit [63:0] total;
            bit [63:0] den;
            bit [95:0] scaled;
            total = 0;
            if (peak == 0)
                return 0;
            for (int i = first; i <= last; i++)
                total += counts[i];
            den = 64'(peak) * 64'(last - first + 1);
            if (total >= den)
                return hpt_pkg::LEVEL_ONE;
            scaled = {16'd0, total, 16'd0};
            return 17'(scaled / den);
        endfunction

        function void note_word(logic [1:0] cmd, logic signed [31:0] sample,
                                logic [9:0] first, logic [9:0] last);
            hpt_tb_pkg::hist_res_t r;
            int unsigned nb;
            longint diff;
            bit [63:0] b;
            nb = (nbins_reg == 0) ? 1
               : (nbins_reg > hpt_pkg::NBINS ? hpt_pkg::NBINS : nbins_reg);
            r = '{default: 0};
            case (cmd)
                hpt_pkg::CMD_CLEAR: wipe();
                hpt_pkg::CMD_ADD: begin
                    diff = longint'(sample) - longint'(lo_edge);
                    if (diff < 0 || span == 0)
                        r.status = hpt_pkg::ST_OUTSIDE;
                    else begin
                        b = (64'(nb) * 64'(diff)) / 64'(span);
                        if (b >= nb)
                            r.status = hpt_pkg::ST_OUTSIDE;
                        else begin
                            if (counts[b] != 32'hFFFF_FFFF)
                                counts[b]++;
                            if (counts[b] > peak) begin
                                peak = counts[b];
                                peak_at = b[9:0];
                            end
                            last_seen[b] = add_index;
                            r.bin = b[9:0];
                        end
                    end
                    add_index++;
                end
                hpt_pkg::CMD_QUERY: begin
                    if (first > last || last >= nb)
                        r.status = hpt_pkg::ST_RANGE;
                    else begin
                        r.level = range_level(first, last);
                        r.last_index = last_seen[first];
                    end
                end
                default: ;
            endcase
            r.peak_count = peak;
            r.peak_bin = peak_at;
            pending = {pending, r};
        endfunction

        function void check_word(hpt_tb_pkg::hist_res_t got);
            hpt_tb_pkg::hist_res_t e;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.bin !== e.bin) begin
                $error("bin exp %0d got %0d", e.bin, got.bin); errors++;
            end
            if (got.peak_count !== e.peak_count) begin
                $error("peak_count exp %0d got %0d", e.peak_count, got.peak_count); errors++;
            end
            if (got.peak_bin !== e.peak_bin) begin
                $error("peak_bin exp %0d got %0d", e.peak_bin, got.peak_bin); errors++;
            end
            if (got.level !== e.level) begin
                $error("level exp %0d got %0d", e.level, got.level); errors++;
            end
            if (got.last_index !== e.last_index) begin
                $error("last_index exp %0d got %0d", e.last_index, got.last_index); errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    always #1 clk = ~clk;

    hpt_in_if  in_ch();
    hpt_out_if out_ch();
    hpt_cfg_if cfg_ch();

    histogram_peak_tracker dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    hist_scoreboard sb;
    bit  rx_stall_on = 1;
    int  idle_cycles = 0;
    localparam int IDLE_LIMIT = 20000;   // covers clearing pass, clear, longest query

    initial begin
        in_ch.valid = 0;
        in_ch.cmd = hpt_pkg::CMD_NOP;
        in_ch.sample = 0;
        in_ch.first_bin = 0;
        in_ch.last_bin = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = hpt_pkg::REG_LOW_EDGE;
        cfg_ch.data = 0;
        sb = new();
        sb.reset_state();
    end

    // Receiver: after each word, a random stall (none when off).
    initial begin
        hpt_tb_pkg::hist_res_t r;
        int wait_n;
        out_ch.ready = 0;
        @(posedge rst_n);
        out_ch.ready <= 1;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                r.status = out_ch.status;
                r.bin = out_ch.bin;
                r.peak_count = out_ch.peak_count;
                r.peak_bin = out_ch.peak_bin;
                r.level = out_ch.level;
                r.last_index = out_ch.last_index;
                sb.check_word(r);
                wait_n = rx_stall_on ? $urandom_range(0, 3) : 0;
                if (wait_n != 0) begin
                    out_ch.ready <= 0;
                    repeat (wait_n) @(posedge clk);
                    out_ch.ready <= 1;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake anywhere.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL histogram_peak_tracker");
            $finish;
        end
    end

    bit tx_gaps_on = 1;

    // valid stays high after an accept so back-to-back words need no extra edge
    task automatic send_word(logic [1:0] cmd, logic signed [31:0] sample,
                             logic [9:0] first, logic [9:0] last);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.cmd <= cmd;
        in_ch.sample <= sample;
        in_ch.first_bin <= first;
        in_ch.last_bin <= last;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_word(cmd, sample, first, last);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [hpt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, d);
    endtask

    task automatic set_cfg(logic [31:0] lo, logic [31:0] w, logic [10:0] nb);
        drain();
        repeat (1100) @(posedge clk);
        write_reg(hpt_pkg::REG_LOW_EDGE, lo);
        write_reg(hpt_pkg::REG_RANGE_WIDTH, w);
        write_reg(hpt_pkg::REG_BIN_COUNT, {21'd0, nb});
        cfg_ch.valid <= 0;
        @(posedge clk);
    endtask

    // Random word: adds dominate, with queries mostly on small ranges.
    task automatic rand_word(int nb);
        int r;
        logic [9:0] f, l;
        logic signed [31:0] s;
        r = $urandom_range(0, 99);
        f = $urandom_range(0, nb - 1);
        l = f + $urandom_range(0, 7);
        if (r < 2)
            send_word(hpt_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
        else if (r < 4)
            send_word(hpt_pkg::CMD_NOP, $urandom, $urandom, $urandom);
        else if (r < 70) begin
            s = (r < 64) ? sb.lo_edge + 32'($urandom_range(0, sb.span > 0 ? sb.span - 1 : 0))
                         : $urandom;
            send_word(hpt_pkg::CMD_ADD, s, $urandom, $urandom);
        end else if (r < 95)
            send_word(hpt_pkg::CMD_QUERY, $urandom, f, l);
        else
            send_word(hpt_pkg::CMD_QUERY, $urandom, $urandom, $urandom);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, every command, out-of-range, invalid queries.
        send_word(hpt_pkg::CMD_QUERY, 0, 0, 0);                 // zero peak
        send_word(hpt_pkg::CMD_ADD, 0, 0, 0);
        send_word(hpt_pkg::CMD_ADD, 65535, 10'h3FF, 10'h3FF);
        send_word(hpt_pkg::CMD_ADD, 65536, 0, 0);               // just past the top
        send_word(hpt_pkg::CMD_ADD, -1, 0, 0);                  // below low edge
        send_word(hpt_pkg::CMD_ADD, 32'sh7FFF_FFFF, 0, 0);
        send_word(hpt_pkg::CMD_ADD, 32'sh8000_0000, 0, 0);
        send_word(hpt_pkg::CMD_ADD, 64, 0, 0);                  // ties do not move the peak
        send_word(hpt_pkg::CMD_ADD, 64, 0, 0);
        send_word(hpt_pkg::CMD_QUERY, 0, 0, 1023);
        send_word(hpt_pkg::CMD_QUERY, 0, 1023, 1023);
        send_word(hpt_pkg::CMD_QUERY, 0, 5, 4);                 // first above last
        send_word(hpt_pkg::CMD_QUERY, 0, 0, 0);
        send_word(hpt_pkg::CMD_NOP, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
        send_word(hpt_pkg::CMD_CLEAR, 0, 0, 0);
        send_word(hpt_pkg::CMD_QUERY, 0, 0, 0);

        // Sender holds off until every result is back.
        drain();

        set_cfg(32'h8000_0000, 32'hFFFF_FFFF, 11'd1024);
        send_word(hpt_pkg::CMD_ADD, 32'sh7FFF_FFFF, 0, 0);
        send_word(hpt_pkg::CMD_ADD, 32'sh8000_0000, 0, 0);
        send_word(hpt_pkg::CMD_QUERY, 0, 0, 1023);
        set_cfg(32'hFFFF_FF00, 32'd0, 11'd0);          // zero width, bin count 0
        send_word(hpt_pkg::CMD_ADD, 0, 0, 0);
        send_word(hpt_pkg::CMD_QUERY, 0, 0, 1);        // last beyond one bin
        set_cfg(32'd100, 32'd1, 11'd2047);             // above NBINS clamps
        send_word(hpt_pkg::CMD_ADD, 100, 0, 0);
        send_word(hpt_pkg::CMD_ADD, 101, 0, 0);
        send_word(hpt_pkg::CMD_QUERY, 0, 0, 1023);

        // Random phases over several settings; small bin counts keep queries short.
        for (int ph = 0; ph < 5; ph++) begin
            int nb;
            nb = (ph == 0) ? 8 : (ph == 1) ? 1 : (ph == 2) ? 64 : (ph == 3) ? 3 : 1024;
            case (ph)
                0: set_cfg(-32'sd50, 32'd40, 11'd8);
                1: set_cfg(32'd0, 32'd10, 11'd1);
                2: set_cfg($urandom, $urandom_range(1, 5000), 11'd64);
                3: set_cfg(32'h7FFF_FFF0, 32'd7, 11'd3);
                default: set_cfg(32'd0, 32'd65536, 11'd1024);
            endcase
            tx_gaps_on = (ph != 1);
            rx_stall_on = (ph != 3);
            for (int i = 0; i < 250; i++)
                rand_word(nb);
        end
        tx_gaps_on = 1;
        rx_stall_on = 1;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS histogram_peak_tracker");
        else
            $display("FAIL histogram_peak_tracker");
        $finish;
    end
endmodule
